[sv/fnv_pkg.sv]
// Shared types, constants and the FNV-1a byte step for the fingerprint block.
`timescale 1ns / 1ps

package fnv_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
    localparam int          BYTES_PER_WORD = 8;
    localparam logic [2:0]  LAST_BYTE = 3'(BYTES_PER_WORD - 1);

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_add;    // first byte of an add word, taken straight from the input
        logic mix_step;    // one byte from the word shifter into the accumulator
        logic write_back;  // store the mixed value into the channel
        logic fin_start;   // accumulator to basis, channel index to zero
        logic emit_chan;   // channel hash to the output, and into the word shifter
        logic emit_comb;   // combined hash to the output, clear every channel
        logic idx_inc;     // next channel
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_free;    // output register may be loaded this cycle
        logic idx_last;    // channel index is at the top channel
        logic ch_ok;       // requested channel exists
    } stat_t;

    // (h ^ b) * 0x100000001B3 mod 2^64, with the prime as a sum of shifts
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

endpackage

[sv/fnv1a64_multichannel_fingerprint.sv]
// Top level of the multichannel FNV-1a 64-bit fingerprint.
// Add word: one byte per cycle through the shift-add prime multiplier, and no new
//   word is taken until its last byte is written back; a word for a missing channel is dropped.
// Finish word: each channel hash goes to the output, then through the same single byte
//   mixer into the combined hash; the sweep waits while the output is stalled.
// Reset (rst_n, async, low): channels to the offset basis, controller idle, output empty.
`timescale 1ns / 1ps

module fnv1a64_multichannel_fingerprint #(
    parameter int NUM_CHANNELS = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [2:0]  channel,
    input  logic [63:0] word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest,
    output logic [2:0]  source,
    output logic        last
);
    import fnv_pkg::*;

    // The controller owns sequencing only: byte count, add/finish mode and the
    // wait on the output register. Everything addressed or wide sits in the
    // datapath, so the two talk through the command and status structs alone.
    cmd_t  cmd;
    stat_t stat;

    fnv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Finish runs the channels in order: each channel hash is loaded into the
    // output register and into the word shifter, then its eight bytes are mixed
    // into the combined accumulator. After the top channel, the combined hash
    // goes out marked last and every channel returns to the basis.
    fnv_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .channel   (channel),
        .word      (word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .digest    (digest),
        .source    (source),
        .last      (last)
    );

`ifndef SYNTHESIS
    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mix_step || cmd.emit_chan) |-> !in_ready)
        else $error("input ready while an operation is in flight");
    a_last_src: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (source == 3'(NUM_CHANNELS % 8)))
        else $error("last word carries a channel source");
    a_finish_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && action) |-> cmd.fin_start)
        else $error("accepted finish did not start the sweep");
`endif

endmodule

[sv/fnv_dp.sv]
// Datapath: channel hash store, byte mixer, word shifter and output register.
`timescale 1ns / 1ps

module fnv_dp #(
    parameter int NUM_CHANNELS = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  fnv_pkg::cmd_t cmd,
    output fnv_pkg::stat_t stat,
    input  logic [2:0]    channel,
    input  logic [63:0]   word,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [63:0]   digest,
    output logic [2:0]    source,
    output logic          last
);
    import fnv_pkg::*;

    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int EXT_W = (CH_W > 3) ? CH_W : 3;
    localparam logic [2:0]      COMB_SRC = 3'(NUM_CHANNELS % 8);
    localparam logic [CH_W-1:0] TOP_IDX  = CH_W'(NUM_CHANNELS - 1);

    logic [63:0]     chan_reg [NUM_CHANNELS];
    logic [63:0]     acc_reg;
    logic [63:0]     word_reg;
    logic [CH_W-1:0] idx_reg;
    logic [CH_W-1:0] ch_reg;
    logic            out_valid_reg;
    logic [63:0]     digest_reg;
    logic [2:0]      source_reg;
    logic            last_reg;

    logic [EXT_W-1:0] in_ext;
    logic [EXT_W-1:0] idx_ext;
    logic [CH_W-1:0]  in_idx;
    logic [63:0]      mix_h;
    logic [7:0]       mix_b;
    logic [63:0]      acc_next;

    assign in_ext  = EXT_W'(channel);
    assign in_idx  = in_ext[CH_W-1:0];
    assign idx_ext = EXT_W'(idx_reg);

    // first byte of an add comes straight from the input port
    assign mix_h    = cmd.load_add ? chan_reg[in_idx] : acc_reg;
    assign mix_b    = cmd.load_add ? word[7:0] : word_reg[7:0];
    assign acc_next = fnv_step(mix_h, mix_b);

    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.idx_last = (idx_reg == TOP_IDX);
    assign stat.ch_ok    = ({29'd0, channel} < 32'(NUM_CHANNELS));

    assign out_valid = out_valid_reg;
    assign digest    = digest_reg;
    assign source    = source_reg;
    assign last      = last_reg;

    // control state and the channel store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                chan_reg[i] <= FNV_BASIS;
            end
        end
        else
        begin
            if (cmd.emit_chan || cmd.emit_comb)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.fin_start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (cmd.write_back)
            begin
                chan_reg[ch_reg] <= acc_next;
            end
            else if (cmd.emit_comb)
            begin
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    chan_reg[i] <= FNV_BASIS;
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_add)
        begin
            acc_reg  <= acc_next;
            word_reg <= word >> 8;
            ch_reg   <= in_idx;
        end
        else if (cmd.fin_start)
        begin
            acc_reg <= FNV_BASIS;
        end
        else if (cmd.emit_chan)
        begin
            word_reg <= chan_reg[idx_reg];
        end
        else if (cmd.mix_step)
        begin
            acc_reg  <= acc_next;
            word_reg <= word_reg >> 8;
        end

        if (cmd.emit_chan)
        begin
            digest_reg <= chan_reg[idx_reg];
            source_reg <= idx_ext[2:0];
            last_reg   <= 1'b0;
        end
        else if (cmd.emit_comb)
        begin
            digest_reg <= acc_reg;
            source_reg <= COMB_SRC;
            last_reg   <= 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_chan || cmd.emit_comb) |-> stat.out_free)
        else $error("output loaded while a word is still held");
    a_add_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_add |-> stat.ch_ok)
        else $error("add started on a channel that does not exist");
    a_comb_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_comb |=> (out_valid_reg && last_reg && source_reg == COMB_SRC))
        else $error("combined digest not presented as last");
    a_comb_top: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_comb |-> stat.idx_last)
        else $error("combined digest before every channel was mixed");
`endif

endmodule

[sv/fnv_ctrl.sv]
// Controller: sequences add and finish operations over the datapath.
`timescale 1ns / 1ps

module fnv_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           action,
    input  fnv_pkg::stat_t stat,
    output fnv_pkg::cmd_t  cmd
);
    import fnv_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MIX,
        S_EMIT,
        S_COMB
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       fin_reg, fin_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        fin_next   = fin_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action)
                    begin
                        cmd.fin_start = 1'b1;
                        fin_next      = 1'b1;
                        state_next    = S_EMIT;
                    end
                    else if (stat.ch_ok)
                    begin
                        // byte 0 mixed here, seven more in S_MIX
                        cmd.load_add = 1'b1;
                        fin_next     = 1'b0;
                        cnt_next     = 3'd1;
                        state_next   = S_MIX;
                    end
                end
            end
            S_MIX:
            begin
                cmd.mix_step = 1'b1;
                cnt_next     = cnt_reg + 3'd1;
                if (cnt_reg == LAST_BYTE)
                begin
                    if (!fin_reg)
                    begin
                        cmd.write_back = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else if (stat.idx_last)
                    begin
                        state_next = S_COMB;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_chan = 1'b1;
                    cnt_next      = 3'd0;
                    state_next    = S_MIX;
                end
            end
            S_COMB:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_comb = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 3'd0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fin_reg   <= fin_next;
        end
    end

endmodule
